// ===== src/abfc_pkg.sv =====
// shared constants for the bounding box builder and frustum cull
package abfc_pkg;

  // plane register layout: a, b, c signed 14 bits each, d signed 22 bits
  localparam int PLANE_W        = 64;
  localparam int NUM_PLANE_REGS = 6;
  localparam int CFG_IDX_W      = 3;
  localparam int COEF_W         = 14;
  localparam int D_W            = 22;
  localparam int D_LSB          = 3 * COEF_W;
  localparam int COORD_FRAC     = 10;
  localparam int AXES           = 3;

  typedef enum logic {
    OP_VERTEX = 1'b0,
    OP_QUERY  = 1'b1
  } abfc_op_t;

endpackage

// ===== src/aabb_build_and_frustum_cull.sv =====
// top level: bounding box builder with a positive-corner frustum cull
//
// Input channel (in_valid/in_ready) takes one request per cycle. A vertex
// request (opcode 0) grows the running box, or restarts it when in_first is
// set. A query request (opcode 1) carries a translation and is tested
// against the first PLANE_COUNT planes. Every request gives one result on
// the out_ channel: visible (0 for vertices) plus the box minimum and size
// as they stand after that request.
// Throughput is one request per cycle. out_valid is registered, the
// request passing three registers: input stage, product stage,
// plane-sum and result register. The box registers update at the
// accepting edge, so a query right behind a vertex sees the grown box.
// When the receiver holds out_ready low, the pipeline stages fill and
// in_ready falls once all three are occupied; nothing is dropped.
// The cfg_ channel writes the plane registers (index 0 to 5) and is always
// ready; write it only while the block is idle.
// Reset clears the box to a point at the origin, zeroes the planes (no
// plane rejects) and empties the pipeline.
module aabb_build_and_frustum_cull #(
  parameter int PLANE_COUNT = 6,
  parameter int COORD_BITS  = 20
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_opcode,
  input  logic                               in_first,
  input  logic signed [COORD_BITS-1:0]       in_coord_x,
  input  logic signed [COORD_BITS-1:0]       in_coord_y,
  input  logic signed [COORD_BITS-1:0]       in_coord_z,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_visible,
  output logic signed [COORD_BITS-1:0]       out_box_min_x,
  output logic signed [COORD_BITS-1:0]       out_box_min_y,
  output logic signed [COORD_BITS-1:0]       out_box_min_z,
  output logic        [COORD_BITS-1:0]       out_box_size_x,
  output logic        [COORD_BITS-1:0]       out_box_size_y,
  output logic        [COORD_BITS-1:0]       out_box_size_z,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [abfc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [abfc_pkg::PLANE_W-1:0]       cfg_data
);
  import abfc_pkg::*;

  localparam int W = COORD_BITS;

  logic                  in_acc;
  logic                  out_ok;
  logic                  s2_ready;
  logic                  s1_ready;

  logic [PLANE_W-1:0]    plane_r [NUM_PLANE_REGS];

  logic signed [W-1:0]   coord   [AXES];
  logic signed [W-1:0]   lo_r    [AXES];
  logic signed [W-1:0]   hi_r    [AXES];
  logic signed [W-1:0]   lo_nxt  [AXES];
  logic signed [W-1:0]   hi_nxt  [AXES];

  logic                  s1_v_r;
  abfc_op_t              s1_op_r;
  logic [AXES-1:0][W-1:0] s1_t_r;
  logic [AXES-1:0][W-1:0] s1_lo_r;
  logic [AXES-1:0][W-1:0] s1_hi_r;

  logic                  s2_v_r;
  abfc_op_t              s2_op_r;
  logic [W-1:0]          s2_min_r  [AXES];
  logic [W-1:0]          s2_size_r [AXES];

  logic                  out_valid_r;
  logic                  out_visible_r;
  logic [W-1:0]          out_min_r  [AXES];
  logic [W-1:0]          out_size_r [AXES];

  logic [PLANE_COUNT-1:0] reject;

  // stall chain: a stage loads when it is empty or its contents move on
  assign out_ok   = !out_valid_r || out_ready;
  assign s2_ready = !s2_v_r || out_ok;
  assign s1_ready = !s1_v_r || s2_ready;
  assign in_ready = s1_ready;
  assign in_acc   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  assign coord[0] = in_coord_x;
  assign coord[1] = in_coord_y;
  assign coord[2] = in_coord_z;

  always_comb begin
    for (int k = 0; k < AXES; k++) begin
      lo_nxt[k] = lo_r[k];
      hi_nxt[k] = hi_r[k];
      if (abfc_op_t'(in_opcode) == OP_VERTEX) begin
        if (in_first) begin
          lo_nxt[k] = coord[k];
          hi_nxt[k] = coord[k];
        end else begin
          if (coord[k] < lo_r[k]) lo_nxt[k] = coord[k];
          if (coord[k] > hi_r[k]) hi_nxt[k] = coord[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < AXES; k++) begin
        lo_r[k] <= '0;
        hi_r[k] <= '0;
      end
      for (int p = 0; p < NUM_PLANE_REGS; p++) plane_r[p] <= '0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        for (int k = 0; k < AXES; k++) begin
          lo_r[k] <= lo_nxt[k];
          hi_r[k] <= hi_nxt[k];
        end
      end
      if (cfg_valid && cfg_ready) begin
        for (int p = 0; p < NUM_PLANE_REGS; p++) begin
          if (cfg_index == CFG_IDX_W'(p)) plane_r[p] <= cfg_data;
        end
      end
      if (s1_ready) s1_v_r <= in_valid;
      if (s2_ready) s2_v_r <= s1_v_r;
      if (out_ok)   out_valid_r <= s2_v_r;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s1_op_r <= abfc_op_t'(in_opcode);
      for (int k = 0; k < AXES; k++) begin
        s1_t_r[k]  <= coord[k];
        s1_lo_r[k] <= lo_nxt[k];
        s1_hi_r[k] <= hi_nxt[k];
      end
    end
    if (s2_ready) begin
      s2_op_r <= s1_op_r;
      for (int k = 0; k < AXES; k++) begin
        s2_min_r[k]  <= s1_lo_r[k];
        s2_size_r[k] <= s1_hi_r[k] - s1_lo_r[k];
      end
    end
    if (out_ok) begin
      out_visible_r <= (s2_op_r == OP_QUERY) && !(|reject);
      for (int k = 0; k < AXES; k++) begin
        out_min_r[k]  <= s2_min_r[k];
        out_size_r[k] <= s2_size_r[k];
      end
    end
  end

  for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_plane
    abfc_plane #(
      .W (W)
    ) u_plane (
      .clk      (clk),
      .load     (s2_ready),
      .plane_i  (plane_r[p]),
      .lo_i     (s1_lo_r),
      .hi_i     (s1_hi_r),
      .t_i      (s1_t_r),
      .reject_o (reject[p])
    );
  end

  assign out_valid      = out_valid_r;
  assign out_visible    = out_visible_r;
  assign out_box_min_x  = out_min_r[0];
  assign out_box_min_y  = out_min_r[1];
  assign out_box_min_z  = out_min_r[2];
  assign out_box_size_x = out_size_r[0];
  assign out_box_size_y = out_size_r[1];
  assign out_box_size_z = out_size_r[2];

  // box is never inverted
  a_box_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    (hi_r[0] >= lo_r[0]) && (hi_r[1] >= lo_r[1]) && (hi_r[2] >= lo_r[2]))
    else $error("box maximum below minimum");

  // a growing vertex never shrinks the box
  a_box_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !in_opcode && !in_first) |=>
      (lo_r[0] <= $past(lo_r[0])) && (hi_r[0] >= $past(hi_r[0])) &&
      (lo_r[1] <= $past(lo_r[1])) && (hi_r[1] >= $past(hi_r[1])) &&
      (lo_r[2] <= $past(lo_r[2])) && (hi_r[2] >= $past(hi_r[2])))
    else $error("box shrank on a vertex");

  // a query leaves the box alone
  a_query_keeps_box: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_opcode) |=>
      $stable(lo_r[0]) && $stable(lo_r[1]) && $stable(lo_r[2]) &&
      $stable(hi_r[0]) && $stable(hi_r[1]) && $stable(hi_r[2]))
    else $error("query changed the box");

  // a stalled product stage keeps its request
  a_s2_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_v_r && !s2_ready) |=> s2_v_r && $stable(s2_op_r))
    else $error("product stage lost a request under stall");

endmodule

// ===== src/abfc_plane.sv =====
// one plane of the cull test: positive corner, products, then sign of the plane sum
module abfc_plane #(
  parameter int W = 20
) (
  input  logic                                   clk,
  input  logic                                   load,
  input  logic [abfc_pkg::PLANE_W-1:0]           plane_i,
  input  logic [abfc_pkg::AXES-1:0][W-1:0]       lo_i,
  input  logic [abfc_pkg::AXES-1:0][W-1:0]       hi_i,
  input  logic [abfc_pkg::AXES-1:0][W-1:0]       t_i,
  output logic                                   reject_o
);
  import abfc_pkg::*;

  localparam int PW    = W + COEF_W + 1;
  localparam int DS_W  = D_W + COORD_FRAC;
  localparam int SUM_W = ((PW > DS_W) ? PW : DS_W) + 2;

  logic signed [COEF_W-1:0] coef     [AXES];
  logic        [W-1:0]      bound    [AXES];
  logic signed [W:0]        corner   [AXES];
  logic signed [PW-1:0]     prod_nxt [AXES];
  logic signed [PW-1:0]     prod_r   [AXES];
  logic signed [D_W-1:0]    d_nxt;
  logic signed [D_W-1:0]    d_r;
  logic signed [DS_W-1:0]   d_scaled;
  logic signed [SUM_W-1:0]  sum;

  always_comb begin
    for (int k = 0; k < AXES; k++) begin
      coef[k]     = plane_i[k*COEF_W +: COEF_W];
      // max on a non-negative coefficient, min otherwise
      bound[k]    = coef[k][COEF_W-1] ? lo_i[k] : hi_i[k];
      corner[k]   = $signed({t_i[k][W-1], t_i[k]}) + $signed({bound[k][W-1], bound[k]});
      prod_nxt[k] = corner[k] * coef[k];
    end
    d_nxt = plane_i[D_LSB +: D_W];
  end

  always_ff @(posedge clk) begin
    if (load) begin
      prod_r <= prod_nxt;
      d_r    <= d_nxt;
    end
  end

  // d moves to the 10 fraction bits of the products
  assign d_scaled = {d_r, {COORD_FRAC{1'b0}}};
  assign sum = SUM_W'(prod_r[0]) + SUM_W'(prod_r[1]) + SUM_W'(prod_r[2]) + SUM_W'(d_scaled);
  assign reject_o = sum[SUM_W-1];

endmodule

// ===== test/tb.sv =====
// testbench for the bounding box builder and frustum cull block
module tb;
  import abfc_pkg::*;

  localparam int PLANE_COUNT = 6;
  localparam int COORD_BITS  = 20;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 150;

  typedef struct packed {
    abfc_op_t              op;
    logic                  first;
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [COORD_BITS-1:0] z;
  } cull_req_t;

  typedef struct packed {
    logic                  visible;
    logic [COORD_BITS-1:0] min_x;
    logic [COORD_BITS-1:0] min_y;
    logic [COORD_BITS-1:0] min_z;
    logic [COORD_BITS-1:0] size_x;
    logic [COORD_BITS-1:0] size_y;
    logic [COORD_BITS-1:0] size_z;
  } cull_result_t;

  logic                         clk;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_ready;
  logic                         in_opcode;
  logic                         in_first;
  logic signed [COORD_BITS-1:0] in_coord_x;
  logic signed [COORD_BITS-1:0] in_coord_y;
  logic signed [COORD_BITS-1:0] in_coord_z;
  logic                         out_valid;
  logic                         out_ready;
  logic                         out_visible;
  logic signed [COORD_BITS-1:0] out_box_min_x;
  logic signed [COORD_BITS-1:0] out_box_min_y;
  logic signed [COORD_BITS-1:0] out_box_min_z;
  logic        [COORD_BITS-1:0] out_box_size_x;
  logic        [COORD_BITS-1:0] out_box_size_y;
  logic        [COORD_BITS-1:0] out_box_size_z;
  logic                         cfg_valid;
  logic                         cfg_ready;
  logic [CFG_IDX_W-1:0]         cfg_index;
  logic [PLANE_W-1:0]           cfg_data;

  // predictor state: box bounds and plane registers
  logic signed [COORD_BITS-1:0] box_lo [AXES];
  logic signed [COORD_BITS-1:0] box_hi [AXES];
  logic [PLANE_W-1:0]           plane_regs [NUM_PLANE_REGS];
  logic [PLANE_W-1:0]           next_planes [NUM_PLANE_REGS];

  cull_req_t    cull_requests [$];
  cull_result_t expected_cull_results [$];
  cull_req_t    cur_req;
  int           requests_queued;
  int           results_checked;
  int           mismatch_count;
  int           send_idle_pct;
  int           stall_pct;
  logic         hold_out;
  int           quiet_cycles;

  aabb_build_and_frustum_cull #(
    .PLANE_COUNT(PLANE_COUNT),
    .COORD_BITS (COORD_BITS)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_opcode     (in_opcode),
    .in_first      (in_first),
    .in_coord_x    (in_coord_x),
    .in_coord_y    (in_coord_y),
    .in_coord_z    (in_coord_z),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_visible   (out_visible),
    .out_box_min_x (out_box_min_x),
    .out_box_min_y (out_box_min_y),
    .out_box_min_z (out_box_min_z),
    .out_box_size_x(out_box_size_x),
    .out_box_size_y(out_box_size_y),
    .out_box_size_z(out_box_size_z),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // updates the box for a vertex, or runs the positive-corner test for a query
  function automatic cull_result_t predict_box_and_cull(input cull_req_t r);
    logic signed [COORD_BITS-1:0] pos [AXES];
    longint coef;
    longint corner;
    longint sum;
    int p;
    int k;
    cull_result_t res;
    pos[0] = r.x;
    pos[1] = r.y;
    pos[2] = r.z;
    res = '0;
    if (r.op == OP_VERTEX) begin
      for (k = 0; k < AXES; k++) begin
        if (r.first) begin
          box_lo[k] = pos[k];
          box_hi[k] = pos[k];
        end else begin
          if (pos[k] < box_lo[k]) box_lo[k] = pos[k];
          if (pos[k] > box_hi[k]) box_hi[k] = pos[k];
        end
      end
    end else begin
      res.visible = 1'b1;
      for (p = 0; p < PLANE_COUNT; p++) begin
        coef = $signed(plane_regs[p][D_LSB +: D_W]);
        sum = coef << COORD_FRAC;
        for (k = 0; k < AXES; k++) begin
          coef = $signed(plane_regs[p][k*COEF_W +: COEF_W]);
          corner = pos[k];
          if (coef >= 0) corner = corner + box_hi[k];
          else corner = corner + box_lo[k];
          sum = sum + corner * coef;
        end
        if (sum < 0) res.visible = 1'b0;
      end
    end
    res.min_x  = box_lo[0];
    res.min_y  = box_lo[1];
    res.min_z  = box_lo[2];
    res.size_x = box_hi[0] - box_lo[0];
    res.size_y = box_hi[1] - box_lo[1];
    res.size_z = box_hi[2] - box_lo[2];
    return res;
  endfunction

  function automatic logic [COORD_BITS-1:0] rand_coord();
    case ($urandom_range(9))
      0: return {1'b1, {(COORD_BITS-1){1'b0}}};
      1: return {1'b0, {(COORD_BITS-1){1'b1}}};
      2: return '0;
      3, 4, 5: return COORD_BITS'($urandom_range(4096) - 2048);
      default: return COORD_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [COEF_W-1:0] rand_coef();
    case ($urandom_range(7))
      0: return {1'b1, {(COEF_W-1){1'b0}}};
      1: return {1'b0, {(COEF_W-1){1'b1}}};
      2: return '0;
      default: return COEF_W'($urandom);
    endcase
  endfunction

  // most planes stay zero so that queries pass often enough
  function automatic logic [PLANE_W-1:0] rand_plane();
    if ($urandom_range(2) != 0) return '0;
    return {D_W'($urandom), rand_coef(), rand_coef(), rand_coef()};
  endfunction

  function automatic logic [PLANE_W-1:0] make_plane(input longint a, input longint b,
                                                    input longint c, input longint d);
    return {d[D_W-1:0], c[COEF_W-1:0], b[COEF_W-1:0], a[COEF_W-1:0]};
  endfunction

  task automatic push_req(input abfc_op_t op, input logic first, input logic [COORD_BITS-1:0] x,
                          input logic [COORD_BITS-1:0] y, input logic [COORD_BITS-1:0] z);
    cull_req_t r;
    r.op    = op;
    r.first = first;
    r.x     = x;
    r.y     = y;
    r.z     = z;
    cull_requests.push_back(r);
    requests_queued++;
  endtask

  // mostly whole boxes followed by queries, the rest loose noise
  task automatic push_random_requests(input int count);
    int n;
    int k;
    n = 0;
    while (n < count) begin
      if ($urandom_range(99) < 85) begin
        push_req(OP_VERTEX, 1'b1, rand_coord(), rand_coord(), rand_coord());
        n++;
        for (k = $urandom_range(6); k > 0; k--) begin
          push_req(OP_VERTEX, 1'b0, rand_coord(), rand_coord(), rand_coord());
          n++;
        end
        for (k = $urandom_range(3, 1); k > 0; k--) begin
          push_req(OP_QUERY, 1'($urandom_range(1)), rand_coord(), rand_coord(), rand_coord());
          n++;
        end
      end else begin
        push_req(abfc_op_t'($urandom_range(1)), 1'($urandom_range(1)),
                 rand_coord(), rand_coord(), rand_coord());
        n++;
      end
    end
  endtask

  // writes next_planes, optionally followed by the unused indexes
  task automatic program_planes(input bit with_spare);
    int i;
    for (i = 0; i < (with_spare ? (1 << CFG_IDX_W) : NUM_PLANE_REGS); i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= i[CFG_IDX_W-1:0];
      if (i < NUM_PLANE_REGS) cfg_data <= next_planes[i];
      else cfg_data <= {$urandom, $urandom};
      do @(posedge clk); while (!cfg_ready);
      if (i < NUM_PLANE_REGS) plane_regs[i] = next_planes[i];
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic randomize_planes();
    int i;
    for (i = 0; i < NUM_PLANE_REGS; i++) next_planes[i] = rand_plane();
  endtask

  task automatic wait_drained();
    while (results_checked < requests_queued) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_cull_results.push_back(predict_box_and_cull(cur_req));
      end
      if (!in_valid || in_ready) begin
        if (cull_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_req = cull_requests.pop_front();
          in_valid   <= 1'b1;
          in_opcode  <= cur_req.op;
          in_first   <= cur_req.first;
          in_coord_x <= cur_req.x;
          in_coord_y <= cur_req.y;
          in_coord_z <= cur_req.z;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin : result_monitor
    cull_result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_cull_results.size() == 0) begin
          $error("result with no request pending");
          mismatch_count++;
        end else begin
          want = expected_cull_results.pop_front();
          check_field("visible", want.visible, out_visible);
          check_field("box_min_x", $signed(want.min_x), out_box_min_x);
          check_field("box_min_y", $signed(want.min_y), out_box_min_y);
          check_field("box_min_z", $signed(want.min_z), out_box_min_z);
          check_field("box_size_x", want.size_x, out_box_size_x);
          check_field("box_size_y", want.size_y, out_box_size_y);
          check_field("box_size_z", want.size_z, out_box_size_z);
          results_checked++;
        end
      end
      out_ready <= !hold_out && ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int i;
    int m;
    logic [COORD_BITS-1:0] cmax;
    logic [COORD_BITS-1:0] cmin;
    cmax = {1'b0, {(COORD_BITS-1){1'b1}}};
    cmin = {1'b1, {(COORD_BITS-1){1'b0}}};
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_opcode  = 1'b0;
    in_first   = 1'b0;
    in_coord_x = '0;
    in_coord_y = '0;
    in_coord_z = '0;
    out_ready  = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    hold_out   = 1'b0;
    send_idle_pct   = 0;
    stall_pct       = 0;
    requests_queued = 0;
    results_checked = 0;
    mismatch_count  = 0;
    quiet_cycles    = 0;
    for (i = 0; i < AXES; i++) begin
      box_lo[i] = '0;
      box_hi[i] = '0;
    end
    for (i = 0; i < NUM_PLANE_REGS; i++) plane_regs[i] = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset planes: nothing rejects; queries before any vertex see the origin
    push_req(OP_QUERY, 1'b0, '0, '0, '0);
    push_req(OP_QUERY, 1'b1, cmax, cmax, cmax);
    push_req(OP_QUERY, 1'b0, cmin, cmin, cmin);
    push_req(OP_VERTEX, 1'b1, cmax, cmax, cmax);
    push_req(OP_VERTEX, 1'b0, cmin, cmin, cmin);
    push_req(OP_VERTEX, 1'b0, '0, '0, '0);
    push_req(OP_QUERY, 1'b0, 20'sd1, -20'sd1, '0);
    push_req(OP_VERTEX, 1'b1, cmin, '0, cmax);
    push_req(OP_VERTEX, 1'b0, cmax, cmin, '0);
    wait_drained();

    // extreme coefficients and offsets
    next_planes[0] = make_plane(-1, -1, -1, -1);
    next_planes[1] = make_plane(8191, -8192, 0, 2097151);
    next_planes[2] = make_plane(-8192, 8191, -8192, -2097152);
    next_planes[3] = make_plane(0, 0, 0, 2097151);
    next_planes[4] = '0;
    next_planes[5] = '1;
    program_planes(1'b1);
    push_req(OP_VERTEX, 1'b1, -20'sd2048, -20'sd2048, -20'sd2048);
    push_req(OP_VERTEX, 1'b0, 20'sd2048, 20'sd2048, 20'sd2048);
    push_req(OP_QUERY, 1'b0, '0, '0, '0);
    push_req(OP_QUERY, 1'b0, cmin, cmin, cmin);
    push_req(OP_QUERY, 1'b0, cmax, cmax, cmax);
    push_req(OP_QUERY, 1'b1, cmin, cmax, cmin);
    wait_drained();

    // single plane x >= 0: corner exactly on the plane is kept
    next_planes[0] = make_plane(4096, 0, 0, 0);
    for (i = 1; i < NUM_PLANE_REGS; i++) next_planes[i] = '0;
    program_planes(1'b0);
    push_req(OP_VERTEX, 1'b1, 20'sd2048, '0, '0);
    push_req(OP_QUERY, 1'b0, -20'sd2049, '0, '0);
    push_req(OP_QUERY, 1'b0, -20'sd2048, '0, '0);
    push_req(OP_VERTEX, 1'b1, cmax, cmax, cmax);
    push_req(OP_QUERY, 1'b0, cmin, cmin, cmin);
    wait_drained();

    for (m = 0; m < 4; m++) begin
      case (m)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 45; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 45; end
        default: begin send_idle_pct = 33; stall_pct = 33; end
      endcase
      randomize_planes();
      program_planes(m == 3);
      push_random_requests(95);
      wait_drained();
    end

    // receiver holds off long enough for the block to back up its input
    send_idle_pct = 0;
    stall_pct     = 0;
    randomize_planes();
    program_planes(1'b0);
    hold_out <= 1'b1;
    push_random_requests(60);
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_out <= 1'b0;
    wait_drained();
    repeat (6) @(posedge clk);

    if (mismatch_count == 0 && expected_cull_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/abfc_pkg.sv
src/abfc_plane.sv
src/aabb_build_and_frustum_cull.sv
test/tb.sv
